// ===== rtl/core/ced_pkg.sv =====
// ---------------------------------------------------------------------------
// ced_pkg: shared types and constants for the C escape decoder
// Result word layout, push bundle between decoder and output queue, sizes.
// ---------------------------------------------------------------------------
package ced_pkg;

    // default width of the decoded length counter
    localparam int LENGTH_BITS_DEF = 16;

    // output queue depth (power of two, at least 2)
    localparam int QUEUE_DEPTH = 4;

    // width of the decoded length field on the result port
    localparam int LEN_OUT_W = 16;

    // one result word
    typedef struct packed {
        logic [7:0]           data_byte;
        logic                 is_end;
        logic [LEN_OUT_W-1:0] length;
    } result_t;

    // up to two result words produced by one input word
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== rtl/core/ced_decode.sv =====
// ---------------------------------------------------------------------------
// ced_decode: escape decoding state machine
// Decodes one raw byte per taken word from the registered mode, numeric
// accumulator and length count; yields up to two result words.
// ---------------------------------------------------------------------------
module ced_decode #(
    parameter int LENGTH_BITS = ced_pkg::LENGTH_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     char_byte,
    input  logic           end_mark,
    output ced_pkg::push_t push
);
    import ced_pkg::*;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_OCT1,
        MODE_OCT2,
        MODE_HEX
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;

    logic [LENGTH_BITS-1:0] cnt1, cnt2;
    logic                   is_oct, is_bsl, hex_ok;
    logic [3:0]             hex_val;
    logic [7:0]             oct_acc, hex_acc;
    logic [7:0]             e0, e1;
    logic [1:0]             num;

    // digit classification
    always_comb
    begin
        is_oct  = (char_byte >= CH_0) && (char_byte <= CH_7);
        is_bsl  = (char_byte == CH_BSL);
        hex_val = char_byte[3:0];
        hex_ok  = 1'b0;
        if ((char_byte >= CH_0) && (char_byte <= CH_9))
        begin
            hex_ok = 1'b1;
        end
        else if (((char_byte >= CH_LA) && (char_byte <= CH_LF)) ||
                 ((char_byte >= CH_UA) && (char_byte <= CH_UF)))
        begin
            // low nibble of a..f / A..F is 1..6
            hex_ok  = 1'b1;
            hex_val = char_byte[3:0] + 4'd9;
        end
        oct_acc = {acc_reg[4:0], char_byte[2:0]};
        hex_acc = {acc_reg[3:0], hex_val};
    end

    // saturating counts after one and two emitted bytes
    always_comb
    begin
        cnt1 = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_ONE;
        cnt2 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + CNT_ONE;
    end

    // next state and emitted bytes
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        num       = 2'd0;
        e0        = 8'h00;
        e1        = 8'h00;
        unique case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_NORMAL;
                if (is_oct)
                begin
                    acc_next  = {5'd0, char_byte[2:0]};
                    mode_next = MODE_OCT1;
                end
                else if (char_byte == CH_X)
                begin
                    acc_next  = 8'h00;
                    mode_next = MODE_HEX;
                end
                else
                begin
                    num = 2'd1;
                    unique case (char_byte)
                        CH_A:              e0 = 8'd7;
                        CH_B:              e0 = 8'd8;
                        CH_F:              e0 = 8'd12;
                        CH_N:              e0 = 8'd10;
                        CH_R:              e0 = 8'd13;
                        CH_T:              e0 = 8'd9;
                        CH_V:              e0 = 8'd11;
                        CH_QUOTE, CH_BSL:  e0 = char_byte;
                        default:
                        begin
                            // unknown escape keeps its backslash
                            num = 2'd2;
                            e0  = CH_BSL;
                            e1  = char_byte;
                        end
                    endcase
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                if (is_oct)
                begin
                    acc_next = oct_acc;
                    if (mode_reg == MODE_OCT1)
                    begin
                        mode_next = MODE_OCT2;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        num       = 2'd1;
                        e0        = oct_acc;
                    end
                end
                else
                begin
                    // flush value, then the byte as ordinary
                    e0        = acc_reg;
                    e1        = char_byte;
                    num       = is_bsl ? 2'd1 : 2'd2;
                    mode_next = is_bsl ? MODE_ESC : MODE_NORMAL;
                end
            end
            MODE_HEX:
            begin
                if (hex_ok)
                begin
                    acc_next = hex_acc;
                end
                else
                begin
                    e0        = acc_reg;
                    e1        = char_byte;
                    num       = is_bsl ? 2'd1 : 2'd2;
                    mode_next = is_bsl ? MODE_ESC : MODE_NORMAL;
                end
            end
            default:
            begin
                e0        = char_byte;
                num       = is_bsl ? 2'd0 : 2'd1;
                mode_next = is_bsl ? MODE_ESC : MODE_NORMAL;
            end
        endcase

        // result words and count
        push.num          = num;
        push.r0.data_byte = e0;
        push.r0.is_end    = 1'b0;
        push.r0.length    = LEN_OUT_W'(cnt1);
        push.r1.data_byte = e1;
        push.r1.is_end    = 1'b0;
        push.r1.length    = LEN_OUT_W'(cnt2);
        case (num)
            2'd1:    cnt_next = cnt1;
            2'd2:    cnt_next = cnt2;
            default: cnt_next = cnt_reg;
        endcase

        // terminator: flush pending numeric escape, report length
        if (end_mark)
        begin
            mode_next = MODE_NORMAL;
            acc_next  = 8'h00;
            cnt_next  = '0;
            if ((mode_reg == MODE_OCT1) || (mode_reg == MODE_OCT2) ||
                (mode_reg == MODE_HEX))
            begin
                push.num          = 2'd2;
                push.r0.data_byte = acc_reg;
                push.r0.is_end    = 1'b0;
                push.r0.length    = LEN_OUT_W'(cnt1);
                push.r1.data_byte = 8'h00;
                push.r1.is_end    = 1'b1;
                push.r1.length    = LEN_OUT_W'(cnt1);
            end
            else
            begin
                push.num          = 2'd1;
                push.r0.data_byte = 8'h00;
                push.r0.is_end    = 1'b1;
                push.r0.length    = LEN_OUT_W'(cnt_reg);
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= 8'h00;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    // a terminator always leaves a fresh string state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && end_mark |=> (mode_reg == MODE_NORMAL) && (cnt_reg == '0))
        else $error("state not cleared after terminator");

    // a terminator always yields its end word
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        take && end_mark |-> (push.num != 2'd0) &&
            ((push.num == 2'd1) ? push.r0.is_end : push.r1.is_end))
        else $error("terminator without end word");

    // count only moves when a word is taken
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(cnt_reg) && $stable(acc_reg))
        else $error("decode state moved without a word");

endmodule

// ===== rtl/core/ced_outq.sv =====
// ---------------------------------------------------------------------------
// ced_outq: result queue
// Small FIFO, up to two results in and one out per cycle unless stalled.
// ---------------------------------------------------------------------------
module ced_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  ced_pkg::push_t   push,
    output logic             room,
    output logic             result_valid,
    input  logic             result_stall,
    output ced_pkg::result_t head
);
    import ced_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);
    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(QUEUE_DEPTH);

    result_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       push_num;
    logic             pop;

    // handshake and pointers
    always_comb
    begin
        push_num     = push_en ? push.num : 2'd0;
        result_valid = (cnt_reg != '0);
        pop          = result_valid && !result_stall;
        room         = (cnt_reg <= ROOM_LIMIT);
        head         = mem_reg[rptr_reg];
        wptr_next    = wptr_reg + PTR_W'(push_num);
        rptr_next    = rptr_reg + PTR_W'(pop);
        cnt_next     = cnt_reg + CNT_W'(push_num) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.r0;
        end
        if (push_num == 2'd2)
        begin
            mem_reg[wptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_num != 2'd0) |-> (cnt_reg <= DEPTH_C - CNT_W'(push_num)))
        else $error("queue overflow");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("queue fill out of range");

    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg == $past(cnt_reg) + CNT_W'($past(push_num))
                            - CNT_W'($past(pop)))
        else $error("queue fill mismatch");

endmodule

// ===== rtl/core/c_escape_decoder.sv =====
// ---------------------------------------------------------------------------
// c_escape_decoder: C escape sequence decoder, one string byte per word
// Path: an accepted input word is held in the input register, then decoded
//   into the result queue, whose head drives the result outputs.
// Throughput: one input word per cycle while the result queue has room; the
//   single output port sets the rate when words produce two results.
// Reset: asynchronous, clears decode mode, accumulator, length and queue.
// ---------------------------------------------------------------------------
module c_escape_decoder #(
    parameter int LENGTH_BITS = ced_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [7:0]                    char_byte,
    input  logic                          end_mark,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [7:0]                    out_byte,
    output logic                          is_end,
    output logic [ced_pkg::LEN_OUT_W-1:0] decoded_length
);
    import ced_pkg::*;

    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_end_reg;
    logic       room, advance, accept;
    push_t      push;
    result_t    head;

    // input register advances when the queue can take two words
    always_comb
    begin
        advance    = stage_valid_reg && room;
        item_stall = stage_valid_reg && !room;
        accept     = item_valid && !item_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= char_byte;
            stage_end_reg  <= end_mark;
        end
    end

    ced_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .char_byte (stage_byte_reg),
        .end_mark  (stage_end_reg),
        .push      (push)
    );

    ced_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_en      (advance),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    // result fields
    assign out_byte       = head.data_byte;
    assign is_end         = head.is_end;
    assign decoded_length = head.length;

endmodule
